/* design/sis_pkg.sv */
package sis_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned FILL_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH        = 3'd0,
    REQ_PUSH_SORTED = 3'd1,
    REQ_POP         = 3'd2,
    REQ_PEEK        = 3'd3,
    REQ_SORT        = 3'd4
  } req_t;

  // per-cycle command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_PUSH_SORTED,
    OP_POP,
    OP_SORT_EVEN,
    OP_SORT_ODD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

/* design/sis_in_if.sv */
interface sis_in_if;
  logic                                valid;
  logic                                ready;
  logic [sis_pkg::REQ_W-1:0]           req_type;
  logic signed [sis_pkg::VAL_W-1:0]    value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

/* design/sis_out_if.sv */
interface sis_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sis_pkg::VAL_W-1:0]    result_value;
  logic                                was_empty;
  logic                                overflow;
  logic [sis_pkg::FILL_W-1:0]          fill_count;

  modport source (output valid, output result_value, output was_empty,
                  output overflow, output fill_count, input ready);
  modport sink   (input valid, input result_value, input was_empty,
                  input overflow, input fill_count, output ready);
endinterface

/* design/sis_cell.sv */
// One stack slot. Cell 0 is the top of the stack.
module sis_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter bit          IS_ODD     = 1'b0
) (
  input  logic                         clk,
  input  sis_pkg::cell_ctl_t           ctl,
  input  logic signed [DATA_WIDTH-1:0] push_val,
  input  logic signed [DATA_WIDTH-1:0] above,
  input  logic signed [DATA_WIDTH-1:0] below,
  input  logic                         valid_self,
  input  logic                         valid_below,
  input  logic                         prefix_in,
  output logic                         prefix_out,
  input  logic                         gt_in,
  output logic                         gt_out,
  output logic signed [DATA_WIDTH-1:0] data_out
);

  logic signed [DATA_WIDTH-1:0] data_r;
  logic signed [DATA_WIDTH-1:0] data_nxt;
  logic                         le_val;
  logic                         upper_role;

  assign le_val     = valid_self && (data_r <= push_val);
  assign prefix_out = prefix_in && le_val;
  // strict compare keeps equal values in place
  assign gt_out     = valid_below && (data_r > below);
  assign data_out   = data_r;

  always_comb begin
    upper_role = 1'b0;
    data_nxt   = data_r;
    unique case (ctl.op)
      sis_pkg::OP_HOLD: data_nxt = data_r;
      sis_pkg::OP_PUSH: data_nxt = above;
      sis_pkg::OP_POP:  data_nxt = below;
      sis_pkg::OP_PUSH_SORTED: begin
        priority if (!prefix_in) begin
          data_nxt = above;
        end else if (le_val) begin
          data_nxt = data_r;
        end else begin
          data_nxt = push_val;
        end
      end
      sis_pkg::OP_SORT_EVEN, sis_pkg::OP_SORT_ODD: begin
        upper_role = (IS_ODD == (ctl.op == sis_pkg::OP_SORT_ODD));
        if (upper_role) begin
          data_nxt = gt_out ? below : data_r;
        end else begin
          data_nxt = gt_in ? above : data_r;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* design/sorted_insert_stack.sv */
// Bounded stack of signed values with sorted insertion, built as a row of
// compare-and-shift cells with the top of the stack in cell 0.
// Input channel in_bus: one beat carries req_type and value. Output channel
// out_bus: exactly one result beat per request, in request order.
// push, push_sorted, pop and peek: the cells shift, insert or read in the
// accept cycle and the result is registered, so it shows on out_bus in the
// cycle after the input beat. A new request is taken every cycle while
// results are drained and no sort is running.
// sort also answers in the cycle after its beat (its result carries only the
// fill count), then runs DEPTH odd-even transposition phases over the cells;
// in_bus.ready is low while those phases run. A stack of zero or one entry
// is not sorted and does not lower in_bus.ready.
// Receiver stall: the single output register holds its beat; in_bus.ready
// drops until that beat is taken or taken in the same cycle.
// Reset (rst_n low, synchronous) empties the stack and clears the output
// valid flag. Entry contents are not cleared; only held entries are read.
module sorted_insert_stack #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sis_in_if.sink    in_bus,
  sis_out_if.source out_bus
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SORT = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] phase_r, phase_nxt;

  logic                                    out_valid_r, out_valid_nxt;
  logic signed [sis_pkg::VAL_W-1:0]        res_r, res_nxt;
  logic                                    empty_r, empty_nxt;
  logic                                    ovf_r, ovf_nxt;
  logic [sis_pkg::FILL_W-1:0]              fill_r;

  sis_pkg::cell_ctl_t            ctl;
  logic signed [DATA_WIDTH-1:0]  push_val;
  logic signed [DATA_WIDTH-1:0]  cell_data [DEPTH];
  logic                          cell_gt   [DEPTH];
  logic                          cell_valid[DEPTH];
  logic                          prefix    [DEPTH+1];
  logic                          accept;
  logic                          full;
  logic                          empty;

  assign in_bus.ready = (state_r == ST_IDLE) && (!out_valid_r || out_bus.ready);
  assign accept       = in_bus.valid && in_bus.ready;
  assign push_val     = DATA_WIDTH'(in_bus.value);
  assign full         = (count_r == CW'(DEPTH));
  assign empty        = (count_r == '0);
  assign prefix[0]    = 1'b1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    phase_nxt = phase_r;
    ctl.op    = sis_pkg::OP_HOLD;
    res_nxt   = '0;
    empty_nxt = 1'b0;
    ovf_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_bus.req_type)
            sis_pkg::REQ_PUSH, sis_pkg::REQ_PUSH_SORTED: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                ctl.op    = (in_bus.req_type == sis_pkg::REQ_PUSH) ?
                            sis_pkg::OP_PUSH : sis_pkg::OP_PUSH_SORTED;
                count_nxt = count_r + CW'(1);
              end
            end
            sis_pkg::REQ_POP, sis_pkg::REQ_PEEK: begin
              if (empty) begin
                empty_nxt = 1'b1;
              end else begin
                res_nxt = sis_pkg::VAL_W'(cell_data[0]);
                if (in_bus.req_type == sis_pkg::REQ_POP) begin
                  ctl.op    = sis_pkg::OP_POP;
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            sis_pkg::REQ_SORT: begin
              if (count_r > CW'(1)) begin
                state_nxt = ST_SORT;
                phase_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SORT: begin
        ctl.op    = phase_r[0] ? sis_pkg::OP_SORT_ODD : sis_pkg::OP_SORT_EVEN;
        phase_nxt = phase_r + PW'(1);
        if (phase_r == PW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r   <= res_nxt;
      empty_r <= empty_nxt;
      ovf_r   <= ovf_nxt;
      fill_r  <= sis_pkg::FILL_W'(count_nxt);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.result_value = res_r;
  assign out_bus.was_empty    = empty_r;
  assign out_bus.overflow     = ovf_r;
  assign out_bus.fill_count   = fill_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] above;
    logic signed [DATA_WIDTH-1:0] below;
    logic                         valid_below;
    logic                         gt_in;

    assign cell_valid[g] = (count_r > CW'(g));

    if (g == 0) begin : g_top
      assign above = push_val;
      assign gt_in = 1'b0;
    end else begin : g_mid
      assign above = cell_data[g-1];
      assign gt_in = cell_gt[g-1];
    end

    if (g == DEPTH - 1) begin : g_bot
      assign below       = '0;
      assign valid_below = 1'b0;
    end else begin : g_nbot
      assign below       = cell_data[g+1];
      assign valid_below = cell_valid[g+1];
    end

    sis_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IS_ODD     (g % 2 == 1)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .push_val    (push_val),
      .above       (above),
      .below       (below),
      .valid_self  (cell_valid[g]),
      .valid_below (valid_below),
      .prefix_in   (prefix[g]),
      .prefix_out  (prefix[g+1]),
      .gt_in       (gt_in),
      .gt_out      (cell_gt[g]),
      .data_out    (cell_data[g])
    );
  end

endmodule

/* design/sis_checker.sv */
module sis_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic    clk,
  input logic    rst_n,
  sis_in_if.sink in_bus,
  sis_out_if.source out_bus
);

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result beat pending after reset");

  // an empty pop or peek returns zero on an empty stack
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.was_empty |->
      out_bus.result_value == '0 && out_bus.fill_count == '0 && !out_bus.overflow)
    else $error("empty flag with non-zero payload");

  // a rejected push leaves the stack full
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.overflow |->
      out_bus.fill_count == sis_pkg::FILL_W'(DEPTH) && out_bus.result_value == '0)
    else $error("overflow flag with stack not full");

  // every accepted request yields a result beat in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> out_bus.valid)
    else $error("accepted request gave no result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.ready |=>
      out_bus.valid && $stable(out_bus.result_value) && $stable(out_bus.fill_count))
    else $error("stalled result beat changed");

endmodule

bind sorted_insert_stack sis_checker #(.DEPTH(DEPTH)) u_sis_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_bus  (in_bus),
  .out_bus (out_bus)
);
